>>> design/pwm_both_strand_scanner_assert.svh
// ----------------------------------------------------------------------------
// PWM scanner assertion macros
// Concurrent check wrappers on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PWM_BOTH_STRAND_SCANNER_ASSERT_SVH
`define PWM_BOTH_STRAND_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PBS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pwm scanner: same-cycle check failed");
`define PBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pwm scanner: next-cycle check failed");
`else
`define PBS_ASSERT_SAME(lbl, ante, cons)
`define PBS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/pbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM scanner package
// Field widths, codes, state type and control structs shared by the scanner.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int SCORE_W    = 22;
    localparam int WEIGHT_W   = 16;
    localparam int BASE_W     = 3;
    localparam int WIN_W      = 20;
    localparam int ROW_W      = 6;
    localparam int NT_W       = 2;
    localparam int LEN_W      = 7;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_BASE   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_END   = 2'd2;

    localparam logic [BASE_W-1:0] BASE_N = 3'd4;
    localparam logic [NT_W-1:0]   NT_T   = 2'd3;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_CLEAR,
        ST_REPLAY
    } t_state;

    typedef struct packed {
        logic                       step;
        logic                       clr;
        logic                       wr_en;
        logic [ROW_W-1:0]           wr_row;
        logic [NT_W-1:0]            wr_nt;
        logic signed [WEIGHT_W-1:0] wr_val;
    } t_cell_ctl;

    typedef struct packed {
        logic run;
        logic clr;
        logic replay;
        logic dirty;
    } t_seq_stat;

endpackage

>>> design/pbs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM scanner cell
// Holds one matrix row and one base of the shift line; extends the forward
// partial sum upwards and the reverse-complement partial sum downwards.
// ----------------------------------------------------------------------------
module pbs_cell import pbs_pkg::*; #(
    parameter int ROW = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic [BASE_W-1:0]         i_bcast,
    input  logic [BASE_W-1:0]         i_base,
    output logic [BASE_W-1:0]         o_base,
    input  logic signed [SCORE_W-1:0] i_fwd,
    output logic signed [SCORE_W-1:0] o_fwd,
    input  logic signed [SCORE_W-1:0] i_rev,
    output logic signed [SCORE_W-1:0] o_rev
);

    logic signed [WEIGHT_W-1:0]   r_wa, r_wc, r_wg, r_wt;
    logic [BASE_W-1:0]            r_base;
    logic signed [SCORE_W-1:0]    r_fwd, r_rev;
    logic signed [WEIGHT_W+1:0]   w_sum;
    logic signed [WEIGHT_W-1:0]   w_mean, w_fterm, w_rterm;
    logic                         w_is_n, w_wr_me;
    logic [NT_W-1:0]              w_nt;

    function automatic logic signed [WEIGHT_W-1:0] pick(
        input logic signed [WEIGHT_W-1:0] wa,
        input logic signed [WEIGHT_W-1:0] wc,
        input logic signed [WEIGHT_W-1:0] wg,
        input logic signed [WEIGHT_W-1:0] wt,
        input logic [NT_W-1:0]            sel
    );
        logic signed [WEIGHT_W-1:0] res;
        case (sel)
            2'd0: res = wa;
            2'd1: res = wc;
            2'd2: res = wg;
            default: res = wt;
        endcase
        return res;
    endfunction

    always_comb begin
        w_sum   = {{2{r_wa[WEIGHT_W-1]}}, r_wa} + {{2{r_wc[WEIGHT_W-1]}}, r_wc}
                + {{2{r_wg[WEIGHT_W-1]}}, r_wg} + {{2{r_wt[WEIGHT_W-1]}}, r_wt};
        w_mean  = w_sum[WEIGHT_W+1:2];
        w_is_n  = (i_bcast >= BASE_N);
        w_nt    = i_bcast[NT_W-1:0];
        w_fterm = w_is_n ? w_mean : pick(r_wa, r_wc, r_wg, r_wt, w_nt);
        w_rterm = w_is_n ? w_mean : pick(r_wa, r_wc, r_wg, r_wt, NT_T - w_nt);
        w_wr_me = i_ctl.wr_en && (int'(i_ctl.wr_row) == ROW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_ctl.step) begin
            r_base <= i_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_fwd <= '0;
            r_rev <= '0;
        end else if (i_ctl.step) begin
            r_fwd <= i_fwd + {{(SCORE_W-WEIGHT_W){w_fterm[WEIGHT_W-1]}}, w_fterm};
            r_rev <= i_rev + {{(SCORE_W-WEIGHT_W){w_rterm[WEIGHT_W-1]}}, w_rterm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_me) begin
            case (i_ctl.wr_nt)
                2'd0: r_wa <= i_ctl.wr_val;
                2'd1: r_wc <= i_ctl.wr_val;
                2'd2: r_wg <= i_ctl.wr_val;
                default: r_wt <= i_ctl.wr_val;
            endcase
        end
    end

    assign o_base = r_base;
    assign o_fwd  = r_fwd;
    assign o_rev  = r_rev;

endmodule

>>> design/pbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM scanner sequencer
// Tracks stale partial sums and rebuilds them by rotating the base line
// once through the chain before the next base is taken.
// ----------------------------------------------------------------------------
module pbs_ctrl import pbs_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_base_req,
    input  logic      i_busy,
    input  logic      i_mark,
    output t_seq_stat o_stat
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_dirty, n_dirty;
    logic             w_last;

    assign w_last = (r_cnt == CNT_W'(MAX_LEN - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (i_base_req && r_dirty && !i_busy) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                n_state = ST_REPLAY;
            end
            ST_REPLAY: begin
                if (w_last) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_comb begin
        o_stat.run    = 1'b0;
        o_stat.clr    = 1'b0;
        o_stat.replay = 1'b0;
        o_stat.dirty  = r_dirty;
        case (r_state)
            ST_RUN:    o_stat.run    = 1'b1;
            ST_CLEAR:  o_stat.clr    = 1'b1;
            ST_REPLAY: o_stat.replay = 1'b1;
            default:   o_stat.run    = 1'b0;
        endcase
    end

    always_comb begin
        n_cnt   = (r_state == ST_REPLAY) ? r_cnt + CNT_W'(1) : '0;
        n_dirty = i_mark || (r_dirty && !((r_state == ST_REPLAY) && w_last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_cnt   <= '0;
            r_dirty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dirty <= n_dirty;
        end
    end

endmodule

>>> design/pwm_both_strand_scanner.sv
`timescale 1ns / 1ps
// Result path: a taken base steps the cells and sets the evaluate flag, then a
// window in the scan range is loaded into the output register once it is free.
// Throughput: one request per cycle, weights and bases alike, while results drain
// and no rebuild is due. The first base after reset, weight loads or a motif_len
// write waits while the chain rebuilds its partial sums from the base line, one base a cycle.
// Reset: control and configuration to defaults, base line to zero; weights unset.
// ----------------------------------------------------------------------------
// PWM both-strand scanner
// Systolic row of matrix cells scoring each window on both strands.
// ----------------------------------------------------------------------------
`include "pwm_both_strand_scanner_assert.svh"

module pwm_both_strand_scanner import pbs_pkg::*; #(
    parameter int MAX_LEN  = 64,
    parameter int POS_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // weight_row[5:0], weight_nt[7:6], weight_value[23:8], base_code[26:24], zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // window_start[19:0], fwd_score[41:20], reverse_score[63:42]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CMP_W = (POS_BITS > WIN_W ? POS_BITS : WIN_W) + 1;
    localparam int LX_W  = ($clog2(MAX_LEN + 1) > LEN_W ? $clog2(MAX_LEN + 1) : LEN_W) + 1;
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [LEN_W-1:0]          r_len;
    logic [WIN_W-1:0]          r_scan_start, r_scan_end;
    logic [POS_BITS-1:0]       r_pos;
    logic                      r_eval, r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;

    logic [ROW_W-1:0]          w_row;
    logic [NT_W-1:0]           w_nt;
    logic signed [WEIGHT_W-1:0] w_val;
    logic [BASE_W-1:0]         w_base_in, w_bcast;
    logic                      w_is_base, w_acc, w_step_in, w_eval_go, w_len_wr, w_hit;
    logic [LX_W-1:0]           w_len_x, w_lm1;
    logic [CMP_W-1:0]          w_p, w_l, w_s, w_ss, w_se;
    logic signed [SCORE_W-1:0] w_fwd_sel;

    t_seq_stat                 seq;
    t_cell_ctl                 cell_ctl;

    logic [BASE_W-1:0]         base_in  [MAX_LEN];
    logic [BASE_W-1:0]         base_out [MAX_LEN];
    logic signed [SCORE_W-1:0] fwd_in   [MAX_LEN];
    logic signed [SCORE_W-1:0] fwd_out  [MAX_LEN];
    logic signed [SCORE_W-1:0] rev_in   [MAX_LEN];
    logic signed [SCORE_W-1:0] rev_out  [MAX_LEN];

    assign w_row     = s_axis_tdata[5:0];
    assign w_nt      = s_axis_tdata[7:6];
    assign w_val     = s_axis_tdata[23:8];
    assign w_base_in = s_axis_tdata[26:24];
    assign w_is_base = (s_axis_tuser == FUNC_BASE);
    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_step_in = w_acc && w_is_base && (r_pos != '1);
    assign w_eval_go = r_eval && (!r_out_valid || m_axis_tready);
    assign w_len_wr  = i_cfg_wr_en && (i_cfg_idx == CFG_MOTIF_LEN);

    assign s_axis_tready = seq.run && !(r_eval && !w_eval_go) && !(seq.dirty && w_is_base);

    pbs_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_base_req (s_axis_tvalid && w_is_base),
        .i_busy     (r_eval),
        .i_mark     ((w_acc && !w_is_base) || w_len_wr),
        .o_stat     (seq)
    );

    always_comb begin
        cell_ctl.step   = w_step_in || seq.replay;
        cell_ctl.clr    = seq.clr;
        cell_ctl.wr_en  = w_acc && !w_is_base;
        cell_ctl.wr_row = w_row;
        cell_ctl.wr_nt  = w_nt;
        cell_ctl.wr_val = w_val;
    end

    assign w_bcast = seq.replay ? base_out[MAX_LEN-1] : w_base_in;
    assign w_len_x = LX_W'(r_len);

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign base_in[j] = w_bcast;
            assign fwd_in[j]  = '0;
        end else begin : g_body
            assign base_in[j] = base_out[j-1];
            assign fwd_in[j]  = fwd_out[j-1];
        end
        if (j == MAX_LEN - 1) begin : g_top
            assign rev_in[j] = '0;
        end else begin : g_mid
            assign rev_in[j] = (LX_W'(j + 1) >= w_len_x) ? '0 : rev_out[j+1];
        end

        pbs_cell #(
            .ROW (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_bcast (w_bcast),
            .i_base  (base_in[j]),
            .o_base  (base_out[j]),
            .i_fwd   (fwd_in[j]),
            .o_fwd   (fwd_out[j]),
            .i_rev   (rev_in[j]),
            .o_rev   (rev_out[j])
        );
    end

    always_comb begin
        w_p       = CMP_W'(r_pos);
        w_l       = CMP_W'(r_len);
        w_ss      = CMP_W'(r_scan_start);
        w_se      = CMP_W'(r_scan_end);
        w_s       = w_p - w_l + CMP_W'(1);
        w_lm1     = w_len_x - LX_W'(1);
        w_fwd_sel = fwd_out[w_lm1[IDX_W-1:0]];
        w_hit     = (r_len != '0) && (w_len_x <= LX_W'(MAX_LEN)) && (w_p >= w_l)
                 && (w_s >= w_ss) && (w_p <= w_se);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= LEN_W'(8);
            r_scan_start <= WIN_W'(1);
            r_scan_end   <= '1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_MOTIF_LEN:  r_len        <= i_cfg_wr_data[LEN_W-1:0];
                CFG_SCAN_START: r_scan_start <= i_cfg_wr_data[WIN_W-1:0];
                CFG_SCAN_END:   r_scan_end   <= i_cfg_wr_data[WIN_W-1:0];
                default:        r_len        <= r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_eval      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step_in) begin
                r_pos <= r_pos + POS_BITS'(1);
            end
            if (w_step_in) begin
                r_eval <= 1'b1;
            end else if (w_eval_go) begin
                r_eval <= 1'b0;
            end
            if (w_eval_go && w_hit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval_go && w_hit) begin
            r_out_data <= {rev_out[0], w_fwd_sel, w_s[WIN_W-1:0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `PBS_ASSERT_SAME(a_no_stale_base, w_acc && w_is_base, !seq.dirty)
    `PBS_ASSERT_SAME(a_rebuild_blocks, seq.replay || seq.clr, !s_axis_tready)
    `PBS_ASSERT_NEXT(a_out_from_eval, !r_out_valid && !r_eval, !m_axis_tvalid)
    `PBS_ASSERT_NEXT(a_pos_holds_full, r_pos == '1, r_pos == '1)

endmodule
